[rtl/core/bbc_pkg.sv]
// Bracket balance checker: shared constants, types and helper functions.
// No dependencies; imported by every module of the block except bbc_stack_ram.
package bbc_pkg;

    // Stack size and position counter width
    localparam int STACK_DEPTH = 64;
    localparam int POS_W       = 16;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Character codes
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LSQUARE   = 8'h5B;
    localparam logic [7:0] CH_RSQUARE   = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_NUL       = 8'h00;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_CODE   = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_STRING = 3'd3,
        MODE_CHAR   = 3'd4
    } lex_mode_t;

    // Result codes
    typedef enum logic [2:0] {
        VERD_BALANCED = 3'd0,
        VERD_NO_OPEN  = 3'd1,
        VERD_MISMATCH = 3'd2,
        VERD_UNCLOSED = 3'd3,
        VERD_OVERFLOW = 3'd4
    } verdict_t;

    // Bracket family, stored in the stack instead of the full character
    typedef enum logic [1:0] {
        BR_PAREN  = 2'd0,
        BR_SQUARE = 2'd1,
        BR_BRACE  = 2'd2
    } br_kind_t;

    typedef struct packed {
        br_kind_t         kind;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } stack_entry_t;

    // Per-byte classification from the scanner
    typedef struct packed {
        logic             is_open;
        logic             is_close;
        br_kind_t         kind;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } scan_info_t;

    // Stack command and status
    typedef struct packed {
        logic         push;
        logic         pop;
        logic         clear;
        stack_entry_t entry;
    } stk_cmd_t;

    typedef struct packed {
        logic         empty;
        logic         full;
        stack_entry_t tos;
    } stk_stat_t;

    // One result word
    typedef struct packed {
        verdict_t         verdict;
        logic [7:0]       ch;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } result_t;

    function automatic br_kind_t kind_of(input logic [7:0] c);
        br_kind_t k;
        if (c == CH_LPAREN || c == CH_RPAREN) begin
            k = BR_PAREN;
        end else if (c == CH_LSQUARE || c == CH_RSQUARE) begin
            k = BR_SQUARE;
        end else begin
            k = BR_BRACE;
        end
        return k;
    endfunction

    // Opening character of a bracket family
    function automatic logic [7:0] open_char(input br_kind_t k);
        logic [7:0] c;
        unique case (k)
            BR_PAREN:  c = CH_LPAREN;
            BR_SQUARE: c = CH_LSQUARE;
            default:   c = CH_LBRACE;
        endcase
        return c;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + POS_W'(1);
    endfunction

endpackage

[rtl/core/bbc_stack_ram.sv]
// Bracket balance checker: generic single-port-write, registered-read RAM.
// No dependencies.
module bbc_stack_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 34,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered, read-before-write
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/bbc_stack.sv]
// Bracket balance checker: open-bracket stack, top entry in a register,
// the rest in bbc_stack_ram. Depends on bbc_pkg and bbc_stack_ram.
module bbc_stack
    import bbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  stk_cmd_t  cmd,
    output stk_stat_t stat
);

    logic [LEVEL_W-1:0] level_reg, level_next;
    stack_entry_t       tos_reg, tos_next;
    logic               fwd_hit_reg, fwd_hit_next;
    stack_entry_t       fwd_data_reg;

    logic [LEVEL_W-1:0] lvl_m1, lvl_next_m2;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    stack_entry_t       rd_data, below;

    // Level update
    always_comb begin
        priority if (cmd.clear) begin
            level_next = '0;
        end else if (cmd.push) begin
            level_next = level_reg + LEVEL_W'(1);
        end else if (cmd.pop) begin
            level_next = level_reg - LEVEL_W'(1);
        end else begin
            level_next = level_reg;
        end
    end

    // Push spills the old top into the RAM; the RAM read always looks
    // one below the next top so a pop finds its new top ready
    assign lvl_m1       = level_reg - LEVEL_W'(1);
    assign lvl_next_m2  = level_next - LEVEL_W'(2);
    assign wr_en        = cmd.push && (level_reg != '0);
    assign wr_addr      = lvl_m1[ADDR_W-1:0];
    assign rd_addr      = lvl_next_m2[ADDR_W-1:0];
    assign fwd_hit_next = wr_en && (wr_addr == rd_addr);

    // Bypass the word written in the same cycle as its read
    assign below = fwd_hit_reg ? fwd_data_reg : rd_data;

    always_comb begin
        priority if (cmd.push) begin
            tos_next = cmd.entry;
        end else if (cmd.pop) begin
            tos_next = below;
        end else begin
            tos_next = tos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            level_reg   <= level_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg      <= tos_next;
        fwd_data_reg <= tos_reg;
    end

    bbc_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH ($bits(stack_entry_t))
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (tos_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == LEVEL_W'(STACK_DEPTH));
    assign stat.tos   = tos_reg;

endmodule

[rtl/core/bbc_scan.sv]
// Bracket balance checker: lexer mode and line/column tracking.
// Depends on bbc_pkg.
module bbc_scan
    import bbc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       clear,
    input  logic [7:0] text_byte,
    output scan_info_t info
);

    lex_mode_t        mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic [7:0]       prev_reg, prev_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W-1:0] col_reg, col_next;

    logic is_open_ch, is_close_ch;

    assign is_open_ch  = (text_byte == CH_LPAREN) || (text_byte == CH_LSQUARE) ||
                         (text_byte == CH_LBRACE);
    assign is_close_ch = (text_byte == CH_RPAREN) || (text_byte == CH_RSQUARE) ||
                         (text_byte == CH_RBRACE);

    // Brackets only count in code
    assign info.is_open  = (mode_reg == MODE_CODE) && is_open_ch;
    assign info.is_close = (mode_reg == MODE_CODE) && is_close_ch;
    assign info.kind     = kind_of(text_byte);
    assign info.line     = line_reg;
    assign info.col      = col_reg;

    // Lexer mode transitions
    always_comb begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        prev_next = text_byte;
        unique case (mode_reg)
            MODE_CODE: begin
                priority if (text_byte == CH_STAR && prev_reg == CH_SLASH) begin
                    mode_next = MODE_BLOCK;
                    prev_next = CH_NUL;
                end else if (text_byte == CH_SLASH && prev_reg == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (text_byte == CH_SQUOTE) begin
                    mode_next = MODE_CHAR;
                end else if (text_byte == CH_DQUOTE) begin
                    mode_next = MODE_STRING;
                end else begin
                    // any other byte leaves the mode alone
                    mode_next = mode_reg;
                end
            end
            MODE_LINE: begin
                if (text_byte == CH_NEWLINE) begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                // opening star is cleared from prev, so it cannot close
                if (text_byte == CH_SLASH && prev_reg == CH_STAR) begin
                    mode_next = MODE_CODE;
                    prev_next = CH_NUL;
                end
            end
            MODE_STRING, MODE_CHAR: begin
                priority if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (text_byte == ((mode_reg == MODE_STRING) ? CH_DQUOTE
                                                                      : CH_SQUOTE)) begin
                    mode_next = MODE_CODE;
                end else if (text_byte == CH_BACKSLASH) begin
                    esc_next = 1'b1;
                end else begin
                    // plain literal content
                    mode_next = mode_reg;
                end
            end
            default: begin
                mode_next = MODE_CODE;
            end
        endcase
    end

    // Position counters, saturating
    always_comb begin
        if (text_byte == CH_NEWLINE) begin
            line_next = sat_inc(line_reg);
            col_next  = POS_W'(1);
        end else begin
            line_next = line_reg;
            col_next  = sat_inc(col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            mode_reg <= MODE_CODE;
            esc_reg  <= 1'b0;
            prev_reg <= CH_NUL;
            line_reg <= POS_W'(1);
            col_reg  <= POS_W'(1);
        end else if (step) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            prev_reg <= prev_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

[rtl/core/bbc_out_buf.sv]
// Bracket balance checker: output register with skid stage for result words.
// Depends on bbc_pkg.
module bbc_out_buf
    import bbc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;
    logic    main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_valid) begin
            skid_reg <= in_data;
        end
    end

endmodule

[rtl/core/c_bracket_balance_checker_core.sv]
// Bracket balance checker: top level, error decision and result formation.
// Depends on bbc_pkg, bbc_scan, bbc_stack and bbc_out_buf.
//
// Takes C source text one byte per word and checks that ( [ { and ) ] }
// pair up outside comments, string and character literals. One byte is
// taken every cycle while s_ready is high, at any mix of pushes and pops:
// the top of stack is a register and the stack RAM is read one entry below
// the next top in the same cycle, with the word just written bypassed, so
// a pop never waits on the RAM. A result word for a byte or end marker goes
// out on m_ through the registered output buffer. s_ready falls only when the
// output register and its skid stage both hold results. The stack RAM needs
// no clearing after reset; the level count alone marks live entries.
module c_bracket_balance_checker_core
    import bbc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_text_byte,
    input  logic             s_end_of_text,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_verdict,
    output logic [7:0]       m_bracket_char,
    output logic [POS_W-1:0] m_line_number,
    output logic [POS_W-1:0] m_column_number
);

    logic         halted_reg, halted_next;
    stack_entry_t oldest_reg, oldest_next;

    logic       accept, fin, step;
    scan_info_t info;
    stk_cmd_t   cmd;
    stk_stat_t  stat;
    logic       res_valid;
    result_t    res, out_res;
    stack_entry_t new_entry;

    assign accept = s_valid && s_ready;
    assign fin    = accept && s_end_of_text;
    assign step   = accept && !s_end_of_text && !halted_reg;

    assign new_entry.kind = info.kind;
    assign new_entry.line = info.line;
    assign new_entry.col  = info.col;

    bbc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .clear     (fin),
        .text_byte (s_text_byte),
        .info      (info)
    );

    // Bracket decision: push, pop or report
    always_comb begin
        cmd.push     = 1'b0;
        cmd.pop      = 1'b0;
        cmd.clear    = fin;
        cmd.entry    = new_entry;
        halted_next  = halted_reg;
        oldest_next  = oldest_reg;
        res_valid    = 1'b0;
        res.verdict  = VERD_BALANCED;
        res.ch       = CH_NUL;
        res.line     = '0;
        res.col      = '0;
        if (fin) begin
            halted_next = 1'b0;
            oldest_next = '0;
            if (!halted_reg) begin
                res_valid = 1'b1;
                if (!stat.empty) begin
                    res.verdict = VERD_UNCLOSED;
                    res.ch      = open_char(oldest_reg.kind);
                    res.line    = oldest_reg.line;
                    res.col     = oldest_reg.col;
                end
            end
        end else if (step && info.is_open) begin
            if (stat.full) begin
                res_valid   = 1'b1;
                halted_next = 1'b1;
                res.verdict = VERD_OVERFLOW;
                res.ch      = s_text_byte;
                res.line    = info.line;
                res.col     = info.col;
            end else begin
                cmd.push = 1'b1;
                if (stat.empty) begin
                    oldest_next = new_entry;
                end
            end
        end else if (step && info.is_close) begin
            priority if (stat.empty) begin
                res_valid   = 1'b1;
                halted_next = 1'b1;
                res.verdict = VERD_NO_OPEN;
                res.ch      = s_text_byte;
                res.line    = info.line;
                res.col     = info.col;
            end else if (stat.tos.kind == info.kind) begin
                cmd.pop = 1'b1;
            end else begin
                res_valid   = 1'b1;
                halted_next = 1'b1;
                res.verdict = VERD_MISMATCH;
                res.ch      = open_char(stat.tos.kind);
                res.line    = stat.tos.line;
                res.col     = stat.tos.col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg <= 1'b0;
            oldest_reg <= '0;
        end else begin
            halted_reg <= halted_next;
            oldest_reg <= oldest_next;
        end
    end

    bbc_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    bbc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_verdict       = out_res.verdict;
    assign m_bracket_char  = out_res.ch;
    assign m_line_number   = out_res.line;
    assign m_column_number = out_res.col;

endmodule
